// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the console line buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Invariant that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant check failed");

`endif

// ===== rtl/clib_pkg.sv =====
// Package with types and constants of the console line buffer.
package clib_pkg;

	// Ring geometry; pointers carry one extra bit to tell full from empty.
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int PTR_W = IDX_W + 1;

	typedef logic [7:0]       char_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PTR_W-1:0] ptr_t;

	// Item kinds.
	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// Character codes with a special meaning.
	localparam char_t CODE_BACKSPACE = 8'd8;
	localparam char_t CODE_ERASE_ALT = 8'd28;
	localparam char_t CODE_CR        = 8'd13;
	localparam char_t CODE_PRINT_MIN = 8'd32;
	localparam char_t CODE_NUL       = 8'd0;

endpackage

// ===== rtl/console_line_input_buffer_core.sv =====
// Console line buffer top level: a 64-entry ring of typed characters with line polling.
// A key item finishes at its accept edge; busy stays low and the next item may follow at once.
// A poll reads one ring entry per cycle and holds busy until its last result is registered.
// Results appear one per cycle once emission is under way and cannot be stalled.
// Reset clears both pointers and the sequencer; ring contents stay unknown until written.
`include "assert_macros.svh"

module console_line_input_buffer_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  clib_pkg::char_t  char_code,
	output logic             strobe,
	output logic             line_found,
	output clib_pkg::char_t  char_out,
	output logic             last
);
	import clib_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	localparam ptr_t DEPTH_P = ptr_t'(DEPTH);

	state_t state_q;
	ptr_t   wp_q;
	ptr_t   rp_q;
	ptr_t   iss_q;
	ptr_t   limit_q;
	logic   chk_q;
	idx_t   chk_off_q;
	logic   strobe_q;
	logic   found_q;
	char_t  char_q;
	logic   last_q;

	char_t  mem_q [DEPTH];
	char_t  rd_data_q;

	logic   accept;
	ptr_t   count;
	logic   is_erase;
	logic   is_append;
	logic   mem_we;
	logic   issue;
	idx_t   rd_idx;

	// Handshake and fill level.
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign count  = wp_q - rp_q;

	// Key decode.
	assign is_erase  = (char_code == CODE_BACKSPACE) || (char_code == CODE_ERASE_ALT);
	assign is_append = (char_code >= CODE_PRINT_MIN) || (char_code == CODE_CR);
	assign mem_we    = accept && (kind == KIND_KEY) && is_append && (count < DEPTH_P);

	// The shared compare decides whether another entry is read this cycle.
	assign issue  = (iss_q < limit_q);
	assign rd_idx = rp_q[IDX_W-1:0] + iss_q[IDX_W-1:0];

	// Ring memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q[IDX_W-1:0]] <= char_code;
		end
		rd_data_q <= mem_q[rd_idx];
	end

	// Sequencer, pointers and registered result outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			iss_q     <= '0;
			limit_q   <= '0;
			chk_q     <= 1'b0;
			chk_off_q <= '0;
			strobe_q  <= 1'b0;
			found_q   <= 1'b0;
			char_q    <= CODE_NUL;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_POLL) begin
							limit_q <= count;
							iss_q   <= '0;
							chk_q   <= 1'b0;
							state_q <= ST_SCAN;
						end else if (is_erase) begin
							if (count != '0) begin
								wp_q <= wp_q - ptr_t'(1);
							end
						end else if (mem_we) begin
							wp_q <= wp_q + ptr_t'(1);
						end
					end
				end
				ST_SCAN: begin
					if (chk_q && (rd_data_q == CODE_CR)) begin
						// Carriage return found: replay the line before it.
						limit_q <= ptr_t'(chk_off_q);
						iss_q   <= '0;
						chk_q   <= 1'b0;
						state_q <= ST_EMIT;
					end else if (!chk_q && !issue) begin
						// Whole fill level walked without a carriage return.
						strobe_q <= 1'b1;
						found_q  <= 1'b0;
						char_q   <= CODE_NUL;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						chk_q     <= issue;
						chk_off_q <= iss_q[IDX_W-1:0];
						if (issue) begin
							iss_q <= iss_q + ptr_t'(1);
						end
					end
				end
				ST_EMIT: begin
					if (chk_q) begin
						strobe_q <= 1'b1;
						found_q  <= 1'b1;
						char_q   <= rd_data_q;
						last_q   <= 1'b0;
					end else if (!issue) begin
						// Terminator, then consume the line and its carriage return.
						strobe_q <= 1'b1;
						found_q  <= 1'b1;
						char_q   <= CODE_NUL;
						last_q   <= 1'b1;
						rp_q     <= rp_q + limit_q + ptr_t'(1);
						state_q  <= ST_IDLE;
					end
					chk_q <= issue;
					if (issue) begin
						iss_q <= iss_q + ptr_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign line_found = found_q;
	assign char_out   = char_q;
	assign last       = last_q;

	// Checks on the ring and the result stream.
	`ASSERT_ALWAYS(a_fill_bound, count <= DEPTH_P)
	`ASSERT_IMPLY(a_not_found_last, strobe && !line_found, last && (char_out == CODE_NUL))
	`ASSERT_IMPLY(a_term_zero, strobe && line_found && last, char_out == CODE_NUL)
	`ASSERT_IMPLY(a_busy_from_poll, $rose(busy), $past(start && (kind == KIND_POLL)))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the console line buffer: key editing, line polls and ring overflow.
module tb;
	import clib_pkg::*;

	// One item as presented on the command ports.
	typedef struct packed {
		logic  kind;
		char_t code;
	} tty_item_t;

	// One answer of a poll as it should appear on the result ports.
	typedef struct packed {
		logic  found;
		char_t ch;
		logic  last;
	} poll_answer_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  kind = KIND_KEY;
	char_t char_code = CODE_NUL;
	logic  busy;
	logic  strobe;
	logic  line_found;
	char_t char_out;
	logic  last;

	tty_item_t    pending_items[$];
	poll_answer_t poll_answers[$];

	// Shadow of the ring and its pointers, kept in step with accepted items.
	char_t ring [DEPTH];
	ptr_t  ring_wr = '0;
	ptr_t  ring_rd = '0;

	int n_total = 0;
	int n_accepted = 0;
	int n_polls = 0;
	int n_lines = 0;
	int n_misses = 0;
	int n_dropped = 0;
	int n_checked = 0;
	int errors = 0;

	console_line_input_buffer_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.char_code  (char_code),
		.strobe     (strobe),
		.line_found (line_found),
		.char_out   (char_out),
		.last       (last)
	);

	always #10 clk = ~clk;

	// Apply one accepted item to the shadow ring and queue the answers a poll produces.
	task automatic apply_to_ring(input logic k, input char_t code);
		ptr_t fill;
		int unsigned pos;
		bit hit;
		fill = ptr_t'(ring_wr - ring_rd);
		if (k == KIND_KEY) begin
			if (code == CODE_BACKSPACE || code == CODE_ERASE_ALT) begin
				if (fill != 0)
					ring_wr = ptr_t'(ring_wr - 1);
			end else if (code >= CODE_PRINT_MIN || code == CODE_CR) begin
				if (fill < DEPTH) begin
					ring[idx_t'(ring_wr)] = code;
					ring_wr = ptr_t'(ring_wr + 1);
				end else begin
					n_dropped++;
				end
			end
		end else begin
			n_polls++;
			pos = 0;
			hit = 1'b0;
			while (pos < fill && !hit) begin
				if (ring[idx_t'(ring_rd + pos)] == CODE_CR)
					hit = 1'b1;
				else
					pos++;
			end
			if (hit) begin
				for (int unsigned j = 0; j < pos; j++)
					poll_answers.push_back('{1'b1, ring[idx_t'(ring_rd + j)], 1'b0});
				poll_answers.push_back('{1'b1, CODE_NUL, 1'b1});
				ring_rd = ptr_t'(ring_rd + pos + 1);
				n_lines++;
			end else begin
				poll_answers.push_back('{1'b0, CODE_NUL, 1'b1});
				n_misses++;
			end
		end
	endtask

	task automatic push_key(input char_t code);
		pending_items.push_back('{KIND_KEY, code});
	endtask

	task automatic push_poll();
		pending_items.push_back('{KIND_POLL, char_t'($urandom_range(0, 255))});
	endtask

	// Driver: record the item accepted at this edge, then present the next one or idle.
	always @(posedge clk) begin
		tty_item_t it;
		bit burst;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				apply_to_ring(kind, char_code);
				n_accepted++;
			end
			if (!start || !busy) begin
				burst = (n_accepted >= 90 && n_accepted < 150);
				if (pending_items.size() > 0 && (burst || $urandom_range(0, 99) >= 37)) begin
					it = pending_items.pop_front();
					start <= 1'b1;
					kind <= it.kind;
					char_code <= it.code;
				end else begin
					start <= 1'b0;
					kind <= 1'($urandom);
					char_code <= char_t'($urandom);
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest outstanding answer.
	always @(posedge clk) begin
		poll_answer_t want;
		if (arst_n && strobe) begin
			if (poll_answers.size() == 0) begin
				$error("unexpected result: line_found=%0d char_out=%0d last=%0d",
					line_found, char_out, last);
				errors++;
			end else begin
				want = poll_answers.pop_front();
				n_checked++;
				if (line_found !== want.found) begin
					$error("line_found: expected %0d, got %0d", want.found, line_found);
					errors++;
				end
				if (char_out !== want.ch) begin
					$error("char_out: expected %0d, got %0d", want.ch, char_out);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					errors++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int len, k, r, scen, n, e;
		char_t c;

		// Directed part: empty polls, erase on empty, ignored codes, empty line,
		// code extremes with both erase codes, and a poll before the line ends.
		push_poll();
		push_key(CODE_BACKSPACE);
		push_key(CODE_ERASE_ALT);
		push_key(CODE_NUL);
		push_key(8'd31);
		push_key(8'd7);
		push_key(CODE_CR);
		push_poll();
		push_key(CODE_PRINT_MIN);
		push_key(8'd255);
		push_key(8'd65);
		push_key(8'd127);
		push_key(8'd128);
		push_key(CODE_BACKSPACE);
		push_key(CODE_ERASE_ALT);
		push_key(CODE_CR);
		push_poll();
		push_key(8'd120);
		push_poll();
		push_key(CODE_CR);
		push_poll();
		push_poll();

		// Random part: mostly typed lines, with lone polls, noise keys and overflow bursts.
		scen = 0;
		while (pending_items.size() < 208) begin
			if (scen != 0)
				scen = $urandom_range(0, 24);
			else
				scen = 1;
			if (scen == 1 || scen == 0) begin
				// Overflow burst: type 62 to 70 keys, around the ring size, trim a little, end the line.
				n = $urandom_range(62, 70);
				for (k = 0; k < n; k++)
					push_key(char_t'($urandom_range(32, 255)));
				e = $urandom_range(0, 2);
				for (k = 0; k < e; k++)
					push_key($urandom_range(0, 1) ? CODE_BACKSPACE : CODE_ERASE_ALT);
				push_key(CODE_CR);
				push_poll();
				scen = 2;
			end else if (scen <= 4) begin
				push_poll();
			end else if (scen <= 6) begin
				push_key(char_t'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(0, 12);
				for (k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 12) begin
						push_key(r[0] ? CODE_BACKSPACE : CODE_ERASE_ALT);
					end else if (r < 20) begin
						do
							c = char_t'($urandom_range(0, 31));
						while (c == CODE_BACKSPACE || c == CODE_CR || c == CODE_ERASE_ALT);
						push_key(c);
					end else begin
						push_key(char_t'($urandom_range(32, 255)));
					end
				end
				// Now and then the line is left open so the poll may find nothing.
				if ($urandom_range(0, 9) != 0)
					push_key(CODE_CR);
				if ($urandom_range(0, 3) != 0)
					push_poll();
			end
		end
		push_poll();
		n_total = pending_items.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_accepted == n_total);
		wait (poll_answers.size() == 0);
		repeat (200) @(posedge clk);
		if (poll_answers.size() != 0) begin
			$error("%0d poll answers never arrived", poll_answers.size());
			errors++;
		end

		$display("Ran %0d items: %0d polls, %0d lines returned, %0d polls without a line.",
			n_total, n_polls, n_lines, n_misses);
		$display("%0d keys dropped on a full ring, %0d results compared.",
			n_dropped, n_checked);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
